/* src/hnctu_pkg.sv */
`default_nettype none
package hnctu_pkg;

    localparam int NBR_SLOTS  = 32;
    localparam int CTL_SLOTS  = 16;
    localparam int ID_BITS    = 16;
    localparam int MAC_BITS   = 48;
    localparam int EHOP_BITS  = 8;
    localparam int NHOP_BITS  = 2;
    localparam int SLOT_BITS  = 5;
    localparam int OUT_BITS   = 3;

    localparam int NB = (NBR_SLOTS > 1) ? $clog2(NBR_SLOTS) : 1;
    localparam int CB = (CTL_SLOTS > 1) ? $clog2(CTL_SLOTS) : 1;
    localparam int SB = (NB > CB) ? NB : CB;

    localparam logic [NHOP_BITS-1:0] ONE_HOP  = NHOP_BITS'(1);
    localparam logic [NHOP_BITS-1:0] TWO_HOPS = NHOP_BITS'(2);

    typedef enum logic [1:0] {
        ACT_HELLO  = 2'd0,
        ACT_CTL    = 2'd1,
        ACT_NBR    = 2'd2,
        ACT_UNUSED = 2'd3
    } action_t;

    typedef enum logic [OUT_BITS-1:0] {
        OUT_UNCHANGED = 3'd0,
        OUT_INSERTED  = 3'd1,
        OUT_UPDATED   = 3'd2,
        OUT_SELF      = 3'd3,
        OUT_FULL      = 3'd4
    } outcome_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NSCAN,
        S_CSCAN,
        S_MACRD,
        S_NINS,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [MAC_BITS-1:0]  mac;
        logic [NHOP_BITS-1:0] hops;
        logic [ID_BITS-1:0]   id;
    } nbr_word_t;

    typedef struct packed {
        logic [NB-1:0]        via_slot;
        logic [EHOP_BITS-1:0] hops;
        logic [ID_BITS-1:0]   id;
    } ctl_word_t;

endpackage
`default_nettype wire

/* src/hnctu_if.sv */
`default_nettype none
interface hnctu_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] node_id;
    logic [7:0]  entry_hops;
    logic [47:0] sender_mac;
    logic        sender_is_controller;

    modport source (output valid, action, node_id, entry_hops, sender_mac,
                    sender_is_controller, input ready);
    modport sink (input valid, action, node_id, entry_hops, sender_mac,
                  sender_is_controller, output ready);
endinterface

interface hnctu_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] neighbor_outcome;
    logic [2:0] controller_outcome;
    logic [4:0] slot;
    logic [7:0] hop_count;

    modport source (output valid, neighbor_outcome, controller_outcome, slot, hop_count,
                    input ready);
    modport sink (input valid, neighbor_outcome, controller_outcome, slot, hop_count,
                  output ready);
endinterface
`default_nettype wire

/* src/hello_neighbor_controller_table_update.sv */
// A header scans the neighbor table, then the controller table for a controller sender;
// an entry scans one table, one entry per cycle, until a match or the last slot.
// One item is in work at a time; the next is accepted once the result is in the output
// register.
// Reset clears the valid and seen bits at once; table memories need no clearing pass.
`default_nettype none
module hello_neighbor_controller_table_update
    import hnctu_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [ID_BITS-1:0] cfg_wr_data,
    hnctu_in_if.sink                in_ch,
    hnctu_out_if.source             out_ch
);

    state_t state_reg, state_next;
    logic [ID_BITS-1:0] own_id_reg;

    logic [NBR_SLOTS-1:0] nbr_valid_reg, nbr_valid_next;
    logic [NBR_SLOTS-1:0] nbr_seen_reg, nbr_seen_next;
    logic [CTL_SLOTS-1:0] ctl_valid_reg, ctl_valid_next;
    logic [NB-1:0] sender_slot_reg, sender_slot_next;
    logic sender_known_reg, sender_known_next;

    action_t act_reg, act_next;
    logic [ID_BITS-1:0] id_reg, id_next;
    logic [EHOP_BITS-1:0] ehops_reg, ehops_next;
    logic [MAC_BITS-1:0] mac_reg, mac_next;
    logic isctl_reg, isctl_next;

    logic [SB-1:0] scan_cnt_reg, scan_cnt_next;
    logic [SB-1:0] pidx_reg, pidx_next;
    logic pend_reg, pend_next;
    logic [NB-1:0] tgt_reg, tgt_next;

    outcome_t nout_reg, nout_next, cout_reg, cout_next;
    logic [SLOT_BITS-1:0] slot_reg, slot_next;
    logic [EHOP_BITS-1:0] hops_reg, hops_next;

    logic ov_reg, ov_next;
    outcome_t onout_reg, onout_next, ocout_reg, ocout_next;
    logic [SLOT_BITS-1:0] oslot_reg, oslot_next;
    logic [EHOP_BITS-1:0] ohops_reg, ohops_next;

    logic nbr_we, ctl_we;
    logic [NB-1:0] nbr_waddr, nbr_raddr;
    logic [CB-1:0] ctl_waddr, ctl_raddr;
    nbr_word_t nbr_wdata, nbr_rdata;
    ctl_word_t ctl_wdata, ctl_rdata;

    logic [NB-1:0] nbr_free;
    logic nbr_free_ok;
    logic [CB-1:0] ctl_free;
    logic ctl_free_ok;
    logic [EHOP_BITS-1:0] new_hops;
    logic nbr_match, ctl_match, nbr_last, ctl_last;

    hnctu_ram #(.WIDTH($bits(nbr_word_t)), .DEPTH(NBR_SLOTS), .ADDR_BITS(NB)) u_nbr_ram (
        .clk   (clk),
        .we    (nbr_we),
        .waddr (nbr_waddr),
        .wdata (nbr_wdata),
        .raddr (nbr_raddr),
        .rdata (nbr_rdata)
    );

    hnctu_ram #(.WIDTH($bits(ctl_word_t)), .DEPTH(CTL_SLOTS), .ADDR_BITS(CB)) u_ctl_ram (
        .clk   (clk),
        .we    (ctl_we),
        .waddr (ctl_waddr),
        .wdata (ctl_wdata),
        .raddr (ctl_raddr),
        .rdata (ctl_rdata)
    );

    always_comb
    begin
        nbr_free    = '0;
        nbr_free_ok = 1'b0;
        for (int i = NBR_SLOTS - 1; i >= 0; i--)
        begin
            if (!nbr_valid_reg[i])
            begin
                nbr_free    = NB'(i);
                nbr_free_ok = 1'b1;
            end
        end
        ctl_free    = '0;
        ctl_free_ok = 1'b0;
        for (int j = CTL_SLOTS - 1; j >= 0; j--)
        begin
            if (!ctl_valid_reg[j])
            begin
                ctl_free    = CB'(j);
                ctl_free_ok = 1'b1;
            end
        end
    end

    assign new_hops  = (ehops_reg == '1) ? '1 : ehops_reg + EHOP_BITS'(1);
    assign nbr_match = nbr_valid_reg[pidx_reg[NB-1:0]] && (nbr_rdata.id == id_reg);
    assign ctl_match = ctl_valid_reg[pidx_reg[CB-1:0]] && (ctl_rdata.id == id_reg);
    assign nbr_last  = (pidx_reg == SB'(NBR_SLOTS - 1));
    assign ctl_last  = (pidx_reg == SB'(CTL_SLOTS - 1));
    assign nbr_raddr = (state_reg == S_MACRD) ? sender_slot_reg : scan_cnt_reg[NB-1:0];
    assign ctl_raddr = scan_cnt_reg[CB-1:0];

    assign in_ch.ready               = (state_reg == S_IDLE);
    assign out_ch.valid              = ov_reg;
    assign out_ch.neighbor_outcome   = onout_reg;
    assign out_ch.controller_outcome = ocout_reg;
    assign out_ch.slot               = oslot_reg;
    assign out_ch.hop_count          = ohops_reg;

    always_comb
    begin
        state_next        = state_reg;
        nbr_valid_next    = nbr_valid_reg;
        nbr_seen_next     = nbr_seen_reg;
        ctl_valid_next    = ctl_valid_reg;
        sender_slot_next  = sender_slot_reg;
        sender_known_next = sender_known_reg;
        act_next          = act_reg;
        id_next           = id_reg;
        ehops_next        = ehops_reg;
        mac_next          = mac_reg;
        isctl_next        = isctl_reg;
        scan_cnt_next     = scan_cnt_reg;
        pidx_next         = pidx_reg;
        pend_next         = pend_reg;
        tgt_next          = tgt_reg;
        nout_next         = nout_reg;
        cout_next         = cout_reg;
        slot_next         = slot_reg;
        hops_next         = hops_reg;
        ov_next           = ov_reg;
        onout_next        = onout_reg;
        ocout_next        = ocout_reg;
        oslot_next        = oslot_reg;
        ohops_next        = ohops_reg;
        nbr_we            = 1'b0;
        nbr_waddr         = '0;
        nbr_wdata         = '0;
        ctl_we            = 1'b0;
        ctl_waddr         = '0;
        ctl_wdata         = '0;

        if (ov_reg && out_ch.ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    act_next      = action_t'(in_ch.action);
                    id_next       = in_ch.node_id;
                    ehops_next    = in_ch.entry_hops;
                    mac_next      = in_ch.sender_mac;
                    isctl_next    = in_ch.sender_is_controller;
                    nout_next     = OUT_UNCHANGED;
                    cout_next     = OUT_UNCHANGED;
                    slot_next     = '0;
                    hops_next     = '0;
                    scan_cnt_next = '0;
                    pend_next     = 1'b0;
                    priority if (action_t'(in_ch.action) == ACT_HELLO)
                    begin
                        state_next = S_NSCAN;
                    end
                    else if (action_t'(in_ch.action) == ACT_UNUSED || !sender_known_reg)
                    begin
                        state_next = S_EMIT;
                    end
                    else if (in_ch.node_id == own_id_reg)
                    begin
                        if (action_t'(in_ch.action) == ACT_CTL)
                        begin
                            cout_next = OUT_SELF;
                        end
                        else
                        begin
                            nout_next = OUT_SELF;
                        end
                        state_next = S_EMIT;
                    end
                    else if (action_t'(in_ch.action) == ACT_CTL)
                    begin
                        state_next = S_CSCAN;
                    end
                    else
                    begin
                        state_next = S_NSCAN;
                    end
                end
            end

            S_NSCAN:
            begin
                scan_cnt_next = scan_cnt_reg + SB'(1);
                pidx_next     = scan_cnt_reg;
                pend_next     = 1'b1;
                if (pend_reg && (nbr_match || nbr_last))
                begin
                    pend_next     = 1'b0;
                    scan_cnt_next = '0;
                    if (act_reg == ACT_HELLO)
                    begin
                        state_next = isctl_reg ? S_CSCAN : S_EMIT;
                        priority if (nbr_match)
                        begin
                            if (nbr_rdata.hops == TWO_HOPS)
                            begin
                                nbr_we    = 1'b1;
                                nbr_waddr = pidx_reg[NB-1:0];
                                nbr_wdata = '{mac: mac_reg, hops: ONE_HOP, id: id_reg};
                                nout_next = OUT_UPDATED;
                                hops_next = EHOP_BITS'(ONE_HOP);
                            end
                            else
                            begin
                                hops_next = EHOP_BITS'(nbr_rdata.hops);
                            end
                            nbr_seen_next[pidx_reg[NB-1:0]] = 1'b1;
                            sender_slot_next  = pidx_reg[NB-1:0];
                            sender_known_next = 1'b1;
                            slot_next         = SLOT_BITS'(pidx_reg[NB-1:0]);
                        end
                        else if (nbr_free_ok)
                        begin
                            nbr_we    = 1'b1;
                            nbr_waddr = nbr_free;
                            nbr_wdata = '{mac: mac_reg, hops: ONE_HOP, id: id_reg};
                            nbr_valid_next[nbr_free] = 1'b1;
                            nbr_seen_next[nbr_free]  = 1'b1;
                            sender_slot_next  = nbr_free;
                            sender_known_next = 1'b1;
                            nout_next = OUT_INSERTED;
                            slot_next = SLOT_BITS'(nbr_free);
                            hops_next = EHOP_BITS'(ONE_HOP);
                        end
                        else
                        begin
                            nout_next         = OUT_FULL;
                            sender_known_next = 1'b0;
                            state_next        = S_EMIT;
                        end
                    end
                    else
                    begin
                        priority if (nbr_match)
                        begin
                            slot_next  = SLOT_BITS'(pidx_reg[NB-1:0]);
                            hops_next  = EHOP_BITS'(nbr_rdata.hops);
                            state_next = S_EMIT;
                        end
                        else if (nbr_free_ok)
                        begin
                            tgt_next   = nbr_free;
                            state_next = S_MACRD;
                        end
                        else
                        begin
                            nout_next  = OUT_FULL;
                            state_next = S_EMIT;
                        end
                    end
                end
            end

            S_MACRD:
            begin
                state_next = S_NINS;
            end

            S_NINS:
            begin
                nbr_we    = 1'b1;
                nbr_waddr = tgt_reg;
                nbr_wdata = '{mac: nbr_rdata.mac, hops: TWO_HOPS, id: id_reg};
                nbr_valid_next[tgt_reg] = 1'b1;
                nbr_seen_next[tgt_reg]  = 1'b0;
                nout_next  = OUT_INSERTED;
                slot_next  = SLOT_BITS'(tgt_reg);
                hops_next  = EHOP_BITS'(TWO_HOPS);
                state_next = S_EMIT;
            end

            S_CSCAN:
            begin
                scan_cnt_next = scan_cnt_reg + SB'(1);
                pidx_next     = scan_cnt_reg;
                pend_next     = 1'b1;
                if (pend_reg && (ctl_match || ctl_last))
                begin
                    pend_next     = 1'b0;
                    scan_cnt_next = '0;
                    state_next    = S_EMIT;
                    ctl_waddr     = ctl_match ? pidx_reg[CB-1:0] : ctl_free;
                    ctl_wdata     = '{via_slot: sender_slot_reg,
                                      hops: (act_reg == ACT_HELLO) ? EHOP_BITS'(1) : new_hops,
                                      id: id_reg};
                    if (act_reg == ACT_HELLO)
                    begin
                        priority if (ctl_match)
                        begin
                            if (ctl_rdata.hops != EHOP_BITS'(1)
                                || ctl_rdata.via_slot != sender_slot_reg)
                            begin
                                ctl_we    = 1'b1;
                                cout_next = OUT_UPDATED;
                            end
                        end
                        else if (ctl_free_ok)
                        begin
                            ctl_we    = 1'b1;
                            ctl_valid_next[ctl_free] = 1'b1;
                            cout_next = OUT_INSERTED;
                        end
                        else
                        begin
                            cout_next = OUT_FULL;
                        end
                    end
                    else
                    begin
                        priority if (ctl_match)
                        begin
                            slot_next = SLOT_BITS'(pidx_reg[CB-1:0]);
                            if (new_hops < ctl_rdata.hops)
                            begin
                                ctl_we    = 1'b1;
                                cout_next = OUT_UPDATED;
                                hops_next = new_hops;
                            end
                            else
                            begin
                                hops_next = ctl_rdata.hops;
                            end
                        end
                        else if (ctl_free_ok)
                        begin
                            ctl_we    = 1'b1;
                            ctl_valid_next[ctl_free] = 1'b1;
                            cout_next = OUT_INSERTED;
                            slot_next = SLOT_BITS'(ctl_free);
                            hops_next = new_hops;
                        end
                        else
                        begin
                            cout_next = OUT_FULL;
                        end
                    end
                end
            end

            S_EMIT:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    ov_next    = 1'b1;
                    onout_next = nout_reg;
                    ocout_next = cout_reg;
                    oslot_next = slot_reg;
                    ohops_next = hops_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            own_id_reg       <= '0;
            nbr_valid_reg    <= '0;
            nbr_seen_reg     <= '0;
            ctl_valid_reg    <= '0;
            sender_slot_reg  <= '0;
            sender_known_reg <= 1'b0;
            scan_cnt_reg     <= '0;
            pend_reg         <= 1'b0;
            ov_reg           <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            if (cfg_wr_en)
            begin
                own_id_reg <= cfg_wr_data;
            end
            nbr_valid_reg    <= nbr_valid_next;
            nbr_seen_reg     <= nbr_seen_next;
            ctl_valid_reg    <= ctl_valid_next;
            sender_slot_reg  <= sender_slot_next;
            sender_known_reg <= sender_known_next;
            scan_cnt_reg     <= scan_cnt_next;
            pend_reg         <= pend_next;
            ov_reg           <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        id_reg    <= id_next;
        ehops_reg <= ehops_next;
        mac_reg   <= mac_next;
        isctl_reg <= isctl_next;
        pidx_reg  <= pidx_next;
        tgt_reg   <= tgt_next;
        nout_reg  <= nout_next;
        cout_reg  <= cout_next;
        slot_reg  <= slot_next;
        hops_reg  <= hops_next;
        onout_reg <= onout_next;
        ocout_reg <= ocout_next;
        oslot_reg <= oslot_next;
        ohops_reg <= ohops_next;
    end

    a_sender_valid: assert property (@(posedge clk) disable iff (!rst_n)
        sender_known_reg |-> nbr_valid_reg[sender_slot_reg])
        else $error("Known sender slot is not a valid neighbor entry.");

    a_nbr_write_valid: assert property (@(posedge clk) disable iff (!rst_n)
        nbr_we |=> nbr_valid_reg[$past(nbr_waddr)])
        else $error("Written neighbor slot did not become valid.");

    a_ctl_write_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_we |=> ctl_valid_reg[$past(ctl_waddr)])
        else $error("Written controller slot did not become valid.");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(state_reg == S_EMIT))
        else $error("Result transfer started outside the emit step.");

endmodule
`default_nettype wire

/* src/hnctu_ram.sv */
`default_nettype none
module hnctu_ram #(
    parameter int WIDTH     = 8,
    parameter int DEPTH     = 32,
    parameter int ADDR_BITS = 5
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire
